// File: hw/rtl/assert_macros.svh
// assertion helpers, all sampled on clk and quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ist_pkg.sv
package ist_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 7;

  // request kinds
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [VALUE_W-1:0] value;
  } ist_req_t;

  typedef struct packed {
    logic               was_present;
    logic [COUNT_W-1:0] member_count;
    logic               full_drop;
  } ist_rsp_t;

  // token and running flags handed from one cell to the next
  typedef struct packed {
    logic tok;
    logic hit;
    logic free;
  } ist_link_t;

endpackage

// File: hw/rtl/ist_cell.sv
module ist_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  ist_pkg::ist_req_t req,
  input  logic              start,
  input  logic              commit,
  input  ist_pkg::ist_link_t link_in,
  output ist_pkg::ist_link_t link_out
);
  import ist_pkg::*;

  logic signed [VALUE_W-1:0] value_r;
  logic                      valid_r, valid_nxt;
  logic                      cand_r, cand_nxt;
  ist_link_t                 link_r, link_nxt;
  logic                      match;

  assign match = valid_r && (value_r == req.value);

  always_comb begin
    link_nxt.tok  = link_in.tok;
    link_nxt.hit  = link_in.hit | match;
    link_nxt.free = link_in.free | ~valid_r;
    // first free slot seen by the token
    cand_nxt = (link_in.tok & ~link_in.free & ~valid_r) | (cand_r & ~start);
    valid_nxt = valid_r;
    if (commit && cand_r) begin
      valid_nxt = 1'b1;
    end else if (link_in.tok && match && (req.kind == KIND_REMOVE)) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cand_r  <= 1'b0;
      link_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      cand_r  <= cand_nxt;
      link_r  <= link_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && cand_r) begin
      value_r <= req.value;
    end
  end

  assign link_out = link_r;

endmodule

// File: hw/rtl/integer_set_table.sv
// Bounded set of signed 32-bit integers held in a row of CAPACITY cells, each with one
// stored value and a valid mark. A request is a lookup, an insert or a remove, and each
// one gives a single result item: whether the value was a member before the request, the
// member count after it (modulo 128) and, for an insert of an absent value into a full set,
// a drop flag. A token carrying the running hit and free-slot flags walks the chain one
// cell per clock; a remove clears the matching cell as the token passes it, and an insert
// is written into the lowest free cell once the token leaves the last cell with no hit.
// One request is in the table at a time; the next is accepted only once the token has left
// the last cell and the result has moved on to the output register, where a finished
// result waits while the next request is accepted. Valid marks clear at reset, so the
// table is usable from the first clock after reset.
module integer_set_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ist_pkg::ist_req_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output ist_pkg::ist_rsp_t out_item
);
  import ist_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // one-hot control states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } ist_state_t;

  ist_state_t       state_r, state_nxt;
  ist_req_t         req_r;
  logic             start_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  ist_rsp_t         res_r, res_nxt;
  ist_rsp_t         out_item_r;
  logic             out_valid_r, out_valid_nxt;

  ist_link_t         link [CAPACITY:0];
  logic [CAPACITY-1:0] tok_vec;

  logic in_acc;
  logic done;
  logic is_ins, is_rem;
  logic commit;
  logic drop;
  logic out_free;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // token enters the first cell with clear flags
  assign link[0].tok  = start_r;
  assign link[0].hit  = 1'b0;
  assign link[0].free = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ist_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .req      (req_r),
      .start    (start_r),
      .commit   (commit),
      .link_in  (link[g]),
      .link_out (link[g+1])
    );
    assign tok_vec[g] = link[g+1].tok;
  end

  // token leaving the last cell carries the verdict for the whole table
  assign done   = (state_r == S_WALK) && link[CAPACITY].tok;
  assign is_ins = (req_r.kind == KIND_INSERT);
  assign is_rem = (req_r.kind == KIND_REMOVE);
  assign commit = done && is_ins && !link[CAPACITY].hit && link[CAPACITY].free;
  assign drop   = is_ins && !link[CAPACITY].hit && !link[CAPACITY].free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    count_nxt = count_r;
    if (commit) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (done && is_rem && link[CAPACITY].hit) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // count carried modulo the field width
  assign cnt_ext = {{COUNT_W{1'b0}}, count_nxt};

  always_comb begin
    res_nxt = res_r;
    if (done) begin
      res_nxt.was_present  = link[CAPACITY].hit;
      res_nxt.member_count = cnt_ext[COUNT_W-1:0];
      res_nxt.full_drop    = drop;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hand the result over once the output register is free
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= in_acc;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_item;
    end
    res_r <= res_nxt;
    if ((state_r == S_DONE) && out_free) begin
      out_item_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // membership never exceeds the number of cells
  `ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(CAPACITY), "member count above capacity")
  // at most one token in the chain
  `ASSERT_ALWAYS(a_tok_single, $onehot0(tok_vec), "more than one token in the chain")
  // a token only leaves the chain while a request is being walked
  `ASSERT_IMPLY(a_tok_walk, link[CAPACITY].tok, state_r == S_WALK,
                "token left the chain outside a walk")
  // an accepted item starts a walk on the next clock
  `ASSERT_NEXT(a_start, in_acc, start_r && (state_r == S_WALK),
               "accepted item did not start a walk")
  // a dropped insert was never a member
  `ASSERT_IMPLY(a_drop_absent, out_valid_r && out_item_r.full_drop, !out_item_r.was_present,
                "drop flagged for a present value")

endmodule
